>>> hdl/sik_pkg.sv
// ----------------------------------------------------------------------------
// sik_pkg
// Types, constants and lookup tables shared by the swerve kinematics block.
// ----------------------------------------------------------------------------
package sik_pkg;

	localparam int WHEEL_COUNT = 4;
	localparam int WHEEL_W     = 2;
	localparam int ANGLE_W     = 16;
	localparam int SPEED_W     = 20;
	localparam int DIM_W       = 12;
	localparam int GAIN_W      = 22;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 22;

	localparam int VEL_W   = 30;
	localparam int MAG_W   = 28;
	localparam int SQ_W    = 58;
	localparam int ROOT_W  = 29;
	localparam int COR_W   = 48;
	localparam int ACC_W   = 25;

	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS   = 29;
	// s1, s2, s3, root stages, product, scale, reciprocal
	localparam int LANE_DEPTH   = 3 + SQRT_STEPS + 3;

	localparam logic [CFG_IDX_W-1:0] REG_TRACK_HALF  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_GAIN    = 2'd2;

	localparam logic [DIM_W-1:0]  TRACK_HALF_RST  = 12'd250;
	localparam logic [DIM_W-1:0]  HALF_LENGTH_RST = 12'd250;
	localparam logic [GAIN_W-1:0] RPM_GAIN_RST    = 22'd12518;

	// corner sign per wheel: bit set means the coordinate is negative
	localparam logic [WHEEL_COUNT-1:0] CORNER_X_NEG = 4'b0110;
	localparam logic [WHEEL_COUNT-1:0] CORNER_Y_NEG = 4'b1100;

	localparam logic [WHEEL_W-1:0] LAST_WHEEL = 2'd3;

	localparam logic signed [ACC_W-1:0] HALF_TURN_ACC = 25'sd4608000;
	localparam logic signed [ACC_W-1:0] ACC_ROUND     = 25'sd128;
	localparam logic signed [ACC_W-1:0] ANGLE_MAX     = 25'sd18000;

	localparam logic [SPEED_W-1:0] SPEED_MAX  = 20'hFFFFF;
	localparam logic [51:0]        SPD_ROUND  = 52'd2048000;
	localparam logic [39:0]        SPD_SAT    = 40'd1048576000;
	localparam logic [30:0]        RECIP_1000 = 31'd1099511628;

	typedef struct packed {
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] yaw_rate;
		logic               calibrated;
		logic signed [15:0] hold_angle_0;
		logic signed [15:0] hold_angle_1;
		logic signed [15:0] hold_angle_2;
		logic signed [15:0] hold_angle_3;
	} cmd_t;

	typedef struct packed {
		logic [WHEEL_W-1:0]        wheel_index;
		logic signed [ANGLE_W-1:0] wheel_angle;
		logic [SPEED_W-1:0]        drive_speed;
		logic                      last_wheel;
	} res_t;

	typedef struct packed {
		logic signed [COR_W-1:0] x;
		logic signed [COR_W-1:0] y;
		logic signed [ACC_W-1:0] a;
	} cor_t;

	// atan(2^-i), 1/256 of 0.01 degree
	function automatic logic signed [ACC_W-1:0] atan_lut(input int i);
		case (i)
			0:       atan_lut = 25'sd1152000;
			1:       atan_lut = 25'sd680065;
			2:       atan_lut = 25'sd359328;
			3:       atan_lut = 25'sd182400;
			4:       atan_lut = 25'sd91554;
			5:       atan_lut = 25'sd45822;
			6:       atan_lut = 25'sd22916;
			7:       atan_lut = 25'sd11459;
			8:       atan_lut = 25'sd5730;
			9:       atan_lut = 25'sd2865;
			10:      atan_lut = 25'sd1432;
			11:      atan_lut = 25'sd716;
			12:      atan_lut = 25'sd358;
			13:      atan_lut = 25'sd179;
			14:      atan_lut = 25'sd90;
			15:      atan_lut = 25'sd45;
			default: atan_lut = 25'sd0;
		endcase
	endfunction

endpackage

>>> hdl/sik_lane.sv
// ----------------------------------------------------------------------------
// sik_lane
// One wheel: wheel velocity, CORDIC steer angle and root-based drive speed.
// ----------------------------------------------------------------------------
module sik_lane (
	input  logic                                clk,
	input  logic                                adv,
	input  logic                                x_neg,
	input  logic                                y_neg,
	input  logic signed [15:0]                  vel_x,
	input  logic signed [15:0]                  vel_y,
	input  logic signed [15:0]                  yaw_rate,
	input  logic signed [15:0]                  hold_angle,
	input  logic [sik_pkg::DIM_W-1:0]           track_half,
	input  logic [sik_pkg::DIM_W-1:0]           half_length,
	input  logic [sik_pkg::GAIN_W-1:0]          rpm_gain,
	output logic signed [sik_pkg::ANGLE_W-1:0]  wheel_angle,
	output logic [sik_pkg::SPEED_W-1:0]         drive_speed
);

	localparam int VW = sik_pkg::VEL_W;
	localparam int SW = sik_pkg::SQ_W;
	localparam int NS = sik_pkg::SQRT_STEPS;
	localparam int CS = sik_pkg::CORDIC_STEPS;

	function automatic sik_pkg::cor_t cor_iter(input sik_pkg::cor_t c, input int i);
		sik_pkg::cor_t r;
		r = c;
		if (c.y >= 0) begin
			r.x = c.x + (c.y >>> i);
			r.y = c.y - (c.x >>> i);
			r.a = c.a + sik_pkg::atan_lut(i);
		end else begin
			r.x = c.x - (c.y >>> i);
			r.y = c.y + (c.x >>> i);
			r.a = c.a - sik_pkg::atan_lut(i);
		end
		return r;
	endfunction

	function automatic logic signed [sik_pkg::ANGLE_W-1:0] ang_final(
		input logic signed [sik_pkg::ACC_W-1:0] a, input logic z,
		input logic signed [15:0] hold);
		logic signed [sik_pkg::ACC_W-1:0] r;
		r = (a + sik_pkg::ACC_ROUND) >>> 8;
		if (r > sik_pkg::ANGLE_MAX)
			r = sik_pkg::ANGLE_MAX;
		if (r < -sik_pkg::ANGLE_MAX)
			r = -sik_pkg::ANGLE_MAX;
		return z ? hold : sik_pkg::ANGLE_W'(r);
	endfunction

	// stage 1: wheel velocity in 1/1000 mm/s
	logic signed [VW-1:0] vxk, vyk, pl, pw, wx_d, wy_d;
	logic signed [VW-1:0] wx_s1, wy_s1;
	logic signed [15:0]   hold_s1;

	always_comb begin
		vxk  = VW'(vel_x) * 30'sd1000;
		vyk  = VW'(vel_y) * 30'sd1000;
		pl   = VW'(signed'({1'b0, half_length})) * VW'(yaw_rate);
		pw   = VW'(signed'({1'b0, track_half})) * VW'(yaw_rate);
		wx_d = y_neg ? vxk + pl : vxk - pl;
		wy_d = x_neg ? vyk - pw : vyk + pw;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1   <= wx_d;
			wy_s1   <= wy_d;
			hold_s1 <= hold_angle;
		end
	end

	// stages 2 and 3: squares and their sum, CORDIC half-turn fold and first iteration
	logic [sik_pkg::MAG_W-1:0] ax, ay;
	logic [55:0]               sqx_s2, sqy_s2;
	sik_pkg::cor_t             cin, cor_s2, cor_s3;
	logic                      zero_s2, zero_s3;
	logic signed [15:0]        hold_s2, hold_s3;
	logic [SW-1:0]             n_s3;

	always_comb begin
		ax    = wx_s1[VW-1] ? sik_pkg::MAG_W'(-wx_s1) : sik_pkg::MAG_W'(wx_s1);
		ay    = wy_s1[VW-1] ? sik_pkg::MAG_W'(-wy_s1) : sik_pkg::MAG_W'(wy_s1);
		cin.x = sik_pkg::COR_W'(wx_s1) <<< 16;
		cin.y = sik_pkg::COR_W'(wy_s1) <<< 16;
		cin.a = '0;
		if (wx_s1 < 0) begin
			cin.x = -cin.x;
			cin.y = -cin.y;
			cin.a = (wy_s1 >= 0) ? sik_pkg::HALF_TURN_ACC : -sik_pkg::HALF_TURN_ACC;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2  <= ax * ax;
			sqy_s2  <= ay * ay;
			cor_s2  <= cin;
			zero_s2 <= (wx_s1 == '0) && (wy_s1 == '0);
			hold_s2 <= hold_s1;
			n_s3    <= SW'(sqx_s2) + SW'(sqy_s2);
			cor_s3  <= cor_iter(cor_s2, 0);
			zero_s3 <= zero_s2;
			hold_s3 <= hold_s2;
		end
	end

	// root stages, CORDIC iterations alongside
	logic [SW-1:0]       rn_s [NS];
	logic [SW-1:0]       rr_s [NS];
	sik_pkg::cor_t       cor_s [CS-1];
	logic                zero_c_s [CS-1];
	logic signed [15:0]  hold_c_s [CS-1];
	logic signed [15:0]  ang_s [NS];

	for (genvar j = 0; j < NS; j++) begin : g_seq
		localparam logic [SW-1:0] BIT = SW'(1) << (2 * (NS - 1 - j));
		logic [SW-1:0] n_in, r_in, trial;
		if (j == 0) begin : g_first
			assign n_in = n_s3;
			assign r_in = '0;
		end else begin : g_next
			assign n_in = rn_s[j-1];
			assign r_in = rr_s[j-1];
		end
		assign trial = r_in + BIT;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (n_in >= trial) begin
					rn_s[j] <= n_in - trial;
					rr_s[j] <= (r_in >> 1) + BIT;
				end else begin
					rn_s[j] <= n_in;
					rr_s[j] <= r_in >> 1;
				end
			end
		end

		if (j < CS - 1) begin : g_cor
			sik_pkg::cor_t      c_in;
			logic               z_in;
			logic signed [15:0] h_in;
			if (j == 0) begin : g_c0
				assign c_in = cor_s3;
				assign z_in = zero_s3;
				assign h_in = hold_s3;
			end else begin : g_cn
				assign c_in = cor_s[j-1];
				assign z_in = zero_c_s[j-1];
				assign h_in = hold_c_s[j-1];
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					cor_s[j]    <= cor_iter(c_in, j + 1);
					zero_c_s[j] <= z_in;
					hold_c_s[j] <= h_in;
				end
			end
			assign ang_s[j] = '0;
		end else if (j == CS - 1) begin : g_ang
			always_ff @(posedge clk) begin
				if (adv)
					ang_s[j] <= ang_final(cor_s[j-1].a, zero_c_s[j-1], hold_c_s[j-1]);
			end
		end else begin : g_carry
			always_ff @(posedge clk) begin
				if (adv)
					ang_s[j] <= ang_s[j-1];
			end
		end
	end

	// speed: product, round and scale, reciprocal of 1000
	logic [50:0]              prod_sa;
	logic [51:0]              rnd;
	logic [39:0]              t_sb;
	logic [29:0]              tlo_sb;
	logic                     sat_sb, sat_sc;
	logic [60:0]              q_sc;
	logic signed [15:0]       ang_sa, ang_sb, ang_sc;

	assign rnd  = 52'(prod_sa) + sik_pkg::SPD_ROUND;
	assign t_sb = rnd[51:12];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_sa <= 51'(rr_s[NS-1][sik_pkg::ROOT_W-1:0]) * 51'(rpm_gain);
			ang_sa  <= ang_s[NS-1];
			sat_sb  <= t_sb >= sik_pkg::SPD_SAT;
			tlo_sb  <= t_sb[29:0];
			ang_sb  <= ang_sa;
			q_sc    <= 61'(tlo_sb) * 61'(sik_pkg::RECIP_1000);
			sat_sc  <= sat_sb;
			ang_sc  <= ang_sb;
		end
	end

	assign wheel_angle = ang_sc;
	assign drive_speed = sat_sc ? sik_pkg::SPEED_MAX : q_sc[59:40];

endmodule

>>> hdl/sik_merge.sv
// ----------------------------------------------------------------------------
// sik_merge
// Holds one four-wheel bundle and sends it out one wheel word at a time.
// ----------------------------------------------------------------------------
module sik_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic signed [sik_pkg::ANGLE_W-1:0]  steer [sik_pkg::WHEEL_COUNT],
	input  logic [sik_pkg::SPEED_W-1:0]         speed [sik_pkg::WHEEL_COUNT],
	output logic                                can_load,
	output logic                                res_valid,
	input  logic                                res_ready,
	output sik_pkg::res_t                       res
);

	logic                               busy_q;
	logic [sik_pkg::WHEEL_W-1:0]        idx_q;
	logic signed [sik_pkg::ANGLE_W-1:0] steer_q [sik_pkg::WHEEL_COUNT];
	logic [sik_pkg::SPEED_W-1:0]        speed_q [sik_pkg::WHEEL_COUNT];
	logic                               take, last;

	assign take     = busy_q && res_ready;
	assign last     = idx_q == sik_pkg::LAST_WHEEL;
	assign can_load = !busy_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= !last;
			idx_q  <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			steer_q <= steer;
			speed_q <= speed;
		end
	end

	assign res_valid       = busy_q;
	assign res.wheel_index = idx_q;
	assign res.wheel_angle = steer_q[idx_q];
	assign res.drive_speed = speed_q[idx_q];
	assign res.last_wheel  = last;

endmodule

>>> hdl/swerve_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics_unit
// Four-wheel swerve drive inverse kinematics: steer angle and drive speed.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | word
// cmd     | in  | cmd_valid / cmd_ready  | sik_pkg::cmd_t, one chassis command
// res     | out | res_valid / res_ready  | sik_pkg::res_t, one wheel result
// cfg     | in  | cfg_we                 | cfg_index, cfg_data
//
// Four lanes, one per wheel, each a 35-stage pipeline (29 root stages set
// the depth); new commands enter while earlier ones are in flight.
// Sustained rate is set by the single result port: four words per command.
// The lanes stall as one when the output bundle is still draining.
// Uncalibrated commands are taken and give no words. Reset clears valids.
module swerve_inverse_kinematics_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  sik_pkg::cmd_t                     cmd,
	output logic                              res_valid,
	input  logic                              res_ready,
	output sik_pkg::res_t                     res,
	input  logic                              cfg_we,
	input  logic [sik_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sik_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int D = sik_pkg::LANE_DEPTH;

	logic [sik_pkg::DIM_W-1:0]  track_half_q, half_length_q;
	logic [sik_pkg::GAIN_W-1:0] rpm_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_half_q  <= sik_pkg::TRACK_HALF_RST;
			half_length_q <= sik_pkg::HALF_LENGTH_RST;
			rpm_gain_q    <= sik_pkg::RPM_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sik_pkg::REG_TRACK_HALF:  track_half_q  <= cfg_data[sik_pkg::DIM_W-1:0];
				sik_pkg::REG_HALF_LENGTH: half_length_q <= cfg_data[sik_pkg::DIM_W-1:0];
				sik_pkg::REG_RPM_GAIN:    rpm_gain_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [D-1:0] vld_q;
	logic         adv, can_load;

	assign adv       = !vld_q[D-1] || can_load;
	assign cmd_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[D-2:0], cmd_valid && cmd.calibrated};
	end

	logic signed [15:0]                 hold [sik_pkg::WHEEL_COUNT];
	logic signed [sik_pkg::ANGLE_W-1:0] steer [sik_pkg::WHEEL_COUNT];
	logic [sik_pkg::SPEED_W-1:0]        speed [sik_pkg::WHEEL_COUNT];

	assign hold[0] = cmd.hold_angle_0;
	assign hold[1] = cmd.hold_angle_1;
	assign hold[2] = cmd.hold_angle_2;
	assign hold[3] = cmd.hold_angle_3;

	for (genvar w = 0; w < sik_pkg::WHEEL_COUNT; w++) begin : g_lane
		sik_lane u_lane (
			.clk         (clk),
			.adv         (adv),
			.x_neg       (sik_pkg::CORNER_X_NEG[w]),
			.y_neg       (sik_pkg::CORNER_Y_NEG[w]),
			.vel_x       (cmd.vel_x),
			.vel_y       (cmd.vel_y),
			.yaw_rate    (cmd.yaw_rate),
			.hold_angle  (hold[w]),
			.track_half  (track_half_q),
			.half_length (half_length_q),
			.rpm_gain    (rpm_gain_q),
			.wheel_angle (steer[w]),
			.drive_speed (speed[w])
		);
	end

	sik_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && vld_q[D-1]),
		.steer     (steer),
		.speed     (speed),
		.can_load  (can_load),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

>>> hdl/sik_checker.sv
// ----------------------------------------------------------------------------
// sik_checker
// Port-level checks on the wheel result sequence.
// ----------------------------------------------------------------------------
module sik_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input sik_pkg::res_t res
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res.last_wheel |=>
		res_valid && res.wheel_index == 2'($past(res.wheel_index) + 2'd1))
		else $error("wheel words out of order");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.last_wheel == (res.wheel_index == sik_pkg::LAST_WHEEL))
		else $error("last wheel flag wrong");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res.last_wheel |=> !res_valid || res.wheel_index == 2'd0)
		else $error("bundle does not start at wheel 0");

endmodule

bind swerve_inverse_kinematics_unit sik_checker u_sik_checker (.*);

>>> tb/tb_swerve_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// tb_swerve_inverse_kinematics_unit
// Self-checking bench for the swerve inverse kinematics unit. Commands are
// sent over a valid/ready channel with random gaps. A predictor computes
// the four wheel words for each calibrated command, and the output process
// compares every returned word in order against them. The geometry and gain
// registers are changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_swerve_inverse_kinematics_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cmd_valid = 1'b0;
	logic                           cmd_ready;
	sik_pkg::cmd_t                  cmd = '0;
	logic                           res_valid;
	logic                           res_ready = 1'b0;
	sik_pkg::res_t                  res;
	logic                           cfg_we = 1'b0;
	logic [sik_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sik_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	sik_pkg::res_t wheel_q[$];
	int            mismatches = 0;
	logic          hold_off = 1'b0;
	event          stall_go;
	logic [11:0]   geo_w = sik_pkg::TRACK_HALF_RST;
	logic [11:0]   geo_l = sik_pkg::HALF_LENGTH_RST;
	logic [21:0]   gain  = sik_pkg::RPM_GAIN_RST;

	swerve_inverse_kinematics_unit i_dut (.*);

	always #4 clk = ~clk;

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [15:0] steer_of(longint vx, longint vy);
		longint x, y, acc, dx, dy;
		longint tab[16] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
			11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};
		x = vx * 65536;
		y = vy * 65536;
		acc = 0;
		if (x < 0) begin
			acc = (y >= 0) ? 18000 * 256 : -18000 * 256;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; acc += tab[i];
			end else begin
				x -= dx; y += dy; acc -= tab[i];
			end
		end
		acc = shr_floor(acc + 128, 8);
		if (acc > 18000) acc = 18000;
		if (acc < -18000) acc = -18000;
		return acc[15:0];
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic predict_wheels(sik_pkg::cmd_t c);
		longint vx, vy, wz, xi, yi, wx, wy;
		longint unsigned mag, spd;
		logic signed [15:0] hold[4];
		sik_pkg::res_t r;
		if (!c.calibrated) return;
		vx = c.vel_x; vy = c.vel_y; wz = c.yaw_rate;
		hold = '{c.hold_angle_0, c.hold_angle_1, c.hold_angle_2, c.hold_angle_3};
		for (int w = 0; w < sik_pkg::WHEEL_COUNT; w++) begin
			xi = sik_pkg::CORNER_X_NEG[w] ? -longint'(geo_w) : longint'(geo_w);
			yi = sik_pkg::CORNER_Y_NEG[w] ? -longint'(geo_l) : longint'(geo_l);
			wx = vx * 1000 - yi * wz;
			wy = vy * 1000 + xi * wz;
			r.wheel_index = 2'(w);
			r.last_wheel = (w == sik_pkg::WHEEL_COUNT - 1);
			if (wx == 0 && wy == 0) begin
				r.wheel_angle = hold[w];
				r.drive_speed = '0;
			end else begin
				mag = root_floor(wx * wx + wy * wy);
				spd = (mag * gain * 16 + 32768000) / 65536000;
				r.drive_speed = (spd > 1048575) ? sik_pkg::SPEED_MAX : spd[19:0];
				r.wheel_angle = steer_of(wx, wy);
			end
			wheel_q.push_back(r);
		end
	endtask

	function automatic int gap_len();
		int p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_cmd(sik_pkg::cmd_t c);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		predict_wheels(c);
		do @(posedge clk); while (!cmd_ready);
	endtask

	// long receiver hold-off, counted here
	initial begin
		forever begin
			@(stall_go);
			hold_off <= 1'b1;
			repeat (300) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	// output side: random stalls plus the long hold-off
	always @(posedge clk) begin
		res_ready <= hold_off ? 1'b0 : ($urandom_range(0, 9) < 7);
		if (arst_n && res_valid && res_ready) begin
			if (wheel_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %p", res);
			end else begin
				if (res !== wheel_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %p got %p", wheel_q[0], res);
				end
				void'(wheel_q.pop_front());
			end
		end
	end

	task automatic drain();
		cmd_valid <= 1'b0;
		while (wheel_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [sik_pkg::CFG_IDX_W-1:0] idx, logic [21:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sik_pkg::REG_TRACK_HALF:  geo_w = val[11:0];
			sik_pkg::REG_HALF_LENGTH: geo_l = val[11:0];
			sik_pkg::REG_RPM_GAIN:    gain = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic sik_pkg::cmd_t rand_cmd();
		sik_pkg::cmd_t c;
		c.vel_x = 16'($urandom);
		c.vel_y = 16'($urandom);
		c.yaw_rate = 16'($urandom);
		if ($urandom_range(0, 3) == 0) c.vel_x = '0;
		if ($urandom_range(0, 3) == 0) c.yaw_rate = '0;
		c.calibrated = ($urandom_range(0, 9) != 0);
		c.hold_angle_0 = 16'($urandom_range(0, 36000) - 18000);
		c.hold_angle_1 = 16'($urandom_range(0, 36000) - 18000);
		c.hold_angle_2 = 16'($urandom_range(0, 36000) - 18000);
		c.hold_angle_3 = 16'($urandom);
		return c;
	endfunction

	function automatic sik_pkg::cmd_t mk(int vx, int vy, int wz, bit cal = 1);
		sik_pkg::cmd_t c;
		c.vel_x = 16'(vx); c.vel_y = 16'(vy); c.yaw_rate = 16'(wz); c.calibrated = cal;
		c.hold_angle_0 = 16'sd18000; c.hold_angle_1 = -16'sd18000;
		c.hold_angle_2 = 16'sd1234; c.hold_angle_3 = -16'sd1;
		return c;
	endfunction

	task automatic test_directed();
		send_cmd(mk(0, 0, 0));
		send_cmd(mk(1000, 0, 0));
		send_cmd(mk(-1000, 0, 0));
		send_cmd(mk(-1000, -1, 0));
		send_cmd(mk(0, 1000, 0));
		send_cmd(mk(0, -1000, 0));
		send_cmd(mk(32767, 32767, 32767));
		send_cmd(mk(-32768, -32768, -32768));
		send_cmd(mk(0, 0, 1000));
		send_cmd(mk(250, 0, 1000));
		send_cmd(mk(500, 500, 0, 0));
		send_cmd(mk(-32768, 32767, 0));
		send_cmd(mk(1, 0, 0));
		drain();
	endtask

	task automatic test_random(int n);
		for (int k = 0; k < n; k++) send_cmd(rand_cmd());
		drain();
	endtask

	task automatic test_backpressure();
		-> stall_go;
		for (int k = 0; k < 30; k++) send_cmd(mk($urandom, $urandom, $urandom));
		drain();
	endtask

	task automatic test_config_extremes();
		write_reg(sik_pkg::REG_TRACK_HALF, 22'd0);
		write_reg(sik_pkg::REG_HALF_LENGTH, 22'd0);
		write_reg(sik_pkg::REG_RPM_GAIN, 22'd0);
		send_cmd(mk(100, 0, 500));
		send_cmd(mk(0, 0, 500));
		test_random(30);
		write_reg(sik_pkg::REG_TRACK_HALF, 22'd4095);
		write_reg(sik_pkg::REG_HALF_LENGTH, 22'd4095);
		write_reg(sik_pkg::REG_RPM_GAIN, 22'h3FFFFF);
		send_cmd(mk(32767, -32768, 32767));
		send_cmd(mk(0, 0, -32768));
		test_random(60);
		write_reg(sik_pkg::REG_TRACK_HALF, 22'($urandom_range(0, 4095)));
		write_reg(sik_pkg::REG_HALF_LENGTH, 22'($urandom_range(0, 4095)));
		write_reg(sik_pkg::REG_RPM_GAIN, 22'($urandom_range(0, 22'h3FFFFF)));
		test_random(50);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(80);
		test_backpressure();
		test_config_extremes();
		if (mismatches == 0 && wheel_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
